// ===== rtl/gsea_pkg.sv =====
// ---------------------------------------------------------------------------
// gsea_pkg: shared types and constants for the gas sensor EMA alarm
// Item layouts, register map, stage codes and register reset values.
// ---------------------------------------------------------------------------
package gsea_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int AVG_BITS    = SAMPLE_BITS + 8;
	localparam int STIMER_BITS = 20;
	localparam int TIMER_BITS  = 16;
	localparam int ALPHA_BITS  = 9;
	localparam int RATIO_BITS  = 10;
	localparam int PROD_BITS   = RATIO_BITS + AVG_BITS;
	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;

	// stage codes
	localparam logic [1:0] STAGE_WARMUP = 2'd0;
	localparam logic [1:0] STAGE_CALIB  = 2'd1;
	localparam logic [1:0] STAGE_RUN    = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_WARMUP_TICKS   = 3'd0;
	localparam logic [2:0] REG_CALIB_TICKS    = 3'd1;
	localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd2;
	localparam logic [2:0] REG_ALPHA_Q8       = 3'd3;
	localparam logic [2:0] REG_RISE_RATIO_Q8  = 3'd4;
	localparam logic [2:0] REG_FALL_RATIO_Q8  = 3'd5;
	localparam logic [2:0] REG_BEEP_ON_TICKS  = 3'd6;
	localparam logic [2:0] REG_BEEP_OFF_TICKS = 3'd7;

	// register reset values
	localparam logic [STIMER_BITS-1:0] RST_WARMUP_TICKS   = 20'd60000;
	localparam logic [STIMER_BITS-1:0] RST_CALIB_TICKS    = 20'd10000;
	localparam logic [TIMER_BITS-1:0]  RST_SAMPLE_PERIOD  = 16'd200;
	localparam logic [ALPHA_BITS-1:0]  RST_ALPHA_Q8       = 9'd38;
	localparam logic [RATIO_BITS-1:0]  RST_RISE_RATIO_Q8  = 10'd282;
	localparam logic [RATIO_BITS-1:0]  RST_FALL_RATIO_Q8  = 10'd269;
	localparam logic [TIMER_BITS-1:0]  RST_BEEP_ON_TICKS  = 16'd120;
	localparam logic [TIMER_BITS-1:0]  RST_BEEP_OFF_TICKS = 16'd120;

	// 1.0 in Q12.8
	localparam logic [AVG_BITS-1:0] AVG_ONE = AVG_BITS'(256);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] adc_sample;
		logic                   comparator_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          stage;
		logic                smoke;
		logic                buzzer_drive;
		logic [AVG_BITS-1:0] average_q8;
	} out_item_t;

	typedef struct packed {
		logic [STIMER_BITS-1:0] warmup_ticks;
		logic [STIMER_BITS-1:0] calib_ticks;
		logic [TIMER_BITS-1:0]  sample_period;
		logic [ALPHA_BITS-1:0]  alpha_q8;
		logic [RATIO_BITS-1:0]  rise_ratio_q8;
		logic [RATIO_BITS-1:0]  fall_ratio_q8;
		logic [TIMER_BITS-1:0]  beep_on_ticks;
		logic [TIMER_BITS-1:0]  beep_off_ticks;
	} cfg_t;

endpackage

// ===== rtl/gas_sensor_ema_alarm_top.sv =====
// ---------------------------------------------------------------------------
// gas_sensor_ema_alarm_top: gas sensor EMA baseline alarm
// One item per millisecond tick in, one status item out per tick.
// ---------------------------------------------------------------------------
// Path: the accepted item sits in the input register, then moves to the result
//   register when it can advance; result valid rises as it is written there.
// Throughput: 1 item per cycle while out_ready holds; the state update is one
//   pass of logic between the input register and the result register.
// Reset (arst_n low, async): pipeline empty, stage warmup, timers/EMA/baseline
//   cleared, alarm and buzzer off, config registers at their defaults.
module gas_sensor_ema_alarm_top
	import gsea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	cfg_t      cfg;
	logic      s1_valid;
	in_item_t  s1_item;
	logic      s2_valid;
	out_item_t s2_item;
	out_item_t core_result;
	logic      advance;
	logic      in_take;

	gsea_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 item moves on when the result register is free or being drained
	assign advance  = s1_valid && (!s2_valid || out_ready);
	assign in_ready = !s1_valid || advance;
	assign in_take  = in_valid && in_ready;

	// state is committed only when the item's result is written
	gsea_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (s1_item),
		.cfg     (cfg),
		.result  (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			s1_valid <= in_take || (s1_valid && !advance);
			s2_valid <= advance || (s2_valid && !out_ready);
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_take)
			s1_item <= in_data;
		if (advance)
			s2_item <= core_result;
	end

	assign out_valid = s2_valid;
	assign out_data  = s2_item;

endmodule

// ===== rtl/gsea_apb_regs.sv =====
// ---------------------------------------------------------------------------
// gsea_apb_regs: configuration register file
// APB-style write/read of the eight setup registers; no wait states.
// ---------------------------------------------------------------------------
module gsea_apb_regs
	import gsea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warmup_ticks   <= RST_WARMUP_TICKS;
			cfg_q.calib_ticks    <= RST_CALIB_TICKS;
			cfg_q.sample_period  <= RST_SAMPLE_PERIOD;
			cfg_q.alpha_q8       <= RST_ALPHA_Q8;
			cfg_q.rise_ratio_q8  <= RST_RISE_RATIO_Q8;
			cfg_q.fall_ratio_q8  <= RST_FALL_RATIO_Q8;
			cfg_q.beep_on_ticks  <= RST_BEEP_ON_TICKS;
			cfg_q.beep_off_ticks <= RST_BEEP_OFF_TICKS;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WARMUP_TICKS:   cfg_q.warmup_ticks   <= pwdata[STIMER_BITS-1:0];
				REG_CALIB_TICKS:    cfg_q.calib_ticks    <= pwdata[STIMER_BITS-1:0];
				REG_SAMPLE_PERIOD:  cfg_q.sample_period  <= pwdata[TIMER_BITS-1:0];
				REG_ALPHA_Q8:       cfg_q.alpha_q8       <= pwdata[ALPHA_BITS-1:0];
				REG_RISE_RATIO_Q8:  cfg_q.rise_ratio_q8  <= pwdata[RATIO_BITS-1:0];
				REG_FALL_RATIO_Q8:  cfg_q.fall_ratio_q8  <= pwdata[RATIO_BITS-1:0];
				REG_BEEP_ON_TICKS:  cfg_q.beep_on_ticks  <= pwdata[TIMER_BITS-1:0];
				REG_BEEP_OFF_TICKS: cfg_q.beep_off_ticks <= pwdata[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WARMUP_TICKS:   prdata = DATA_BITS'(cfg_q.warmup_ticks);
			REG_CALIB_TICKS:    prdata = DATA_BITS'(cfg_q.calib_ticks);
			REG_SAMPLE_PERIOD:  prdata = DATA_BITS'(cfg_q.sample_period);
			REG_ALPHA_Q8:       prdata = DATA_BITS'(cfg_q.alpha_q8);
			REG_RISE_RATIO_Q8:  prdata = DATA_BITS'(cfg_q.rise_ratio_q8);
			REG_FALL_RATIO_Q8:  prdata = DATA_BITS'(cfg_q.fall_ratio_q8);
			REG_BEEP_ON_TICKS:  prdata = DATA_BITS'(cfg_q.beep_on_ticks);
			REG_BEEP_OFF_TICKS: prdata = DATA_BITS'(cfg_q.beep_off_ticks);
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== rtl/gsea_ema.sv =====
// ---------------------------------------------------------------------------
// gsea_ema: EMA fold of one sample
// avg' = (a*x*256 + (256-a)*avg + 128) >> 8, or x*256 when empty.
// ---------------------------------------------------------------------------
module gsea_ema
	import gsea_pkg::*;
(
	input  logic [ALPHA_BITS-1:0]  alpha_q8,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [AVG_BITS-1:0]    avg,
	input  logic                   avg_valid,
	output logic [AVG_BITS-1:0]    avg_next
);

	localparam int NEW_BITS = ALPHA_BITS + SAMPLE_BITS;
	localparam int OLD_BITS = ALPHA_BITS + AVG_BITS;
	localparam int ACC_BITS = OLD_BITS + 1;

	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(256);

	logic [ALPHA_BITS-1:0] a_new;
	logic [ALPHA_BITS-1:0] a_old;
	logic [NEW_BITS-1:0]   prod_new;
	logic [OLD_BITS-1:0]   prod_old;
	logic [ACC_BITS-1:0]   acc;

	// weights above one act as one
	assign a_new    = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
	assign a_old    = ALPHA_ONE - a_new;
	assign prod_new = NEW_BITS'(a_new) * NEW_BITS'(sample);
	assign prod_old = OLD_BITS'(a_old) * OLD_BITS'(avg);
	assign acc      = ACC_BITS'({prod_new, 8'b0}) + ACC_BITS'(prod_old) + ACC_BITS'(128);

	assign avg_next = avg_valid ? acc[AVG_BITS+7:8] : {sample, 8'b0};

endmodule

// ===== rtl/gsea_core.sv =====
// ---------------------------------------------------------------------------
// gsea_core: per-tick state update
// Timers, stage sequencing, baseline latch, ratio alarm and beep pattern.
// ---------------------------------------------------------------------------
module gsea_core
	import gsea_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	logic [1:0]             stage_q, stage_n;
	logic [STIMER_BITS-1:0] stage_timer_q, stage_timer_inc, stage_timer_n;
	logic [TIMER_BITS-1:0]  sample_timer_q, sample_timer_inc, sample_timer_n;
	logic [TIMER_BITS-1:0]  beep_timer_q, beep_timer_inc, beep_timer_n;
	logic [AVG_BITS-1:0]    avg_q, avg_fold, avg_n;
	logic                   avg_valid_q, avg_valid_n;
	logic [AVG_BITS-1:0]    base_q, base_n;
	logic                   alarm_q, alarm_n;
	logic                   beep_active_q, beep_active_n;
	logic                   beep_sound_q, beep_sound_n;

	logic                   fire;
	logic                   enter_run;
	logic [RATIO_BITS-1:0]  ratio;
	logic [PROD_BITS-1:0]   ratio_prod;
	logic                   ratio_hit;
	logic                   run;

	gsea_ema u_ema (
		.alpha_q8  (cfg.alpha_q8),
		.sample    (item.adc_sample),
		.avg       (avg_q),
		.avg_valid (avg_valid_q),
		.avg_next  (avg_fold)
	);

	// saturating tick counters
	assign stage_timer_inc  = (&stage_timer_q) ? stage_timer_q : stage_timer_q + 1'b1;
	assign sample_timer_inc = (&sample_timer_q) ? sample_timer_q : sample_timer_q + 1'b1;
	assign beep_timer_inc   = (&beep_timer_q) ? beep_timer_q : beep_timer_q + 1'b1;
	assign fire             = sample_timer_inc >= cfg.sample_period;

	always_comb begin
		stage_n        = stage_q;
		stage_timer_n  = stage_timer_inc;
		sample_timer_n = sample_timer_inc;
		avg_n          = avg_q;
		avg_valid_n    = avg_valid_q;
		base_n         = base_q;
		enter_run      = 1'b0;
		if (fire) begin
			sample_timer_n = '0;
			avg_n          = avg_fold;
			avg_valid_n    = 1'b1;
			unique case (stage_q)
				STAGE_WARMUP: begin
					if (stage_timer_inc >= cfg.warmup_ticks) begin
						avg_valid_n   = 1'b0;
						stage_timer_n = '0;
						stage_n       = STAGE_CALIB;
					end
				end
				STAGE_CALIB: begin
					if (stage_timer_inc >= cfg.calib_ticks) begin
						base_n    = (avg_fold < AVG_ONE) ? AVG_ONE : avg_fold;
						stage_n   = STAGE_RUN;
						enter_run = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ratio test: avg*256 >= ratio*baseline; product taken from registers only
	assign ratio      = alarm_q ? cfg.fall_ratio_q8 : cfg.rise_ratio_q8;
	assign ratio_prod = PROD_BITS'(ratio) * PROD_BITS'(base_q);

	always_comb begin
		if (enter_run) begin
			// baseline is max(avg, 1.0) this tick, so the product reduces
			if (avg_n >= AVG_ONE)
				ratio_hit = AVG_BITS'(ratio) <= AVG_ONE;
			else
				ratio_hit = avg_n >= AVG_BITS'(ratio);
		end else begin
			ratio_hit = (base_q != '0) && (PROD_BITS'({avg_n, 8'b0}) >= ratio_prod);
		end
		ratio_hit = ratio_hit && avg_valid_n;
	end

	assign run     = stage_n == STAGE_RUN;
	assign alarm_n = run ? (ratio_hit || !item.comparator_level) : alarm_q;

	// beep pattern
	always_comb begin
		beep_timer_n  = beep_timer_inc;
		beep_active_n = beep_active_q;
		beep_sound_n  = beep_sound_q;
		if (!run || !alarm_n) begin
			beep_active_n = 1'b0;
			beep_sound_n  = 1'b0;
		end else if (!beep_active_q) begin
			beep_active_n = 1'b1;
			beep_sound_n  = 1'b1;
			beep_timer_n  = '0;
		end else if (beep_sound_q && beep_timer_inc >= cfg.beep_on_ticks) begin
			beep_sound_n = 1'b0;
			beep_timer_n = '0;
		end else if (!beep_sound_q && beep_timer_inc >= cfg.beep_off_ticks) begin
			beep_sound_n = 1'b1;
			beep_timer_n = '0;
		end
	end

	assign result.stage        = stage_n;
	assign result.smoke        = alarm_n;
	assign result.buzzer_drive = beep_sound_n;
	assign result.average_q8   = avg_valid_n ? avg_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q        <= STAGE_WARMUP;
			stage_timer_q  <= '0;
			sample_timer_q <= '0;
			beep_timer_q   <= '0;
			avg_q          <= '0;
			avg_valid_q    <= 1'b0;
			base_q         <= '0;
			alarm_q        <= 1'b0;
			beep_active_q  <= 1'b0;
			beep_sound_q   <= 1'b0;
		end else if (advance) begin
			stage_q        <= stage_n;
			stage_timer_q  <= stage_timer_n;
			sample_timer_q <= sample_timer_n;
			beep_timer_q   <= beep_timer_n;
			avg_q          <= avg_n;
			avg_valid_q    <= avg_valid_n;
			base_q         <= base_n;
			alarm_q        <= alarm_n;
			beep_active_q  <= beep_active_n;
			beep_sound_q   <= beep_sound_n;
		end
	end

endmodule

// ===== rtl/gsea_checker.sv =====
// ---------------------------------------------------------------------------
// gsea_checker: port-level checks for the gas sensor EMA alarm
// Watches result items and handshakes; bound to the top level.
// ---------------------------------------------------------------------------
module gsea_checker
	import gsea_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// alarm only while running
	a_smoke_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.smoke |-> out_data.stage == STAGE_RUN)
		else $error("smoke outside run stage");

	// buzzer only sounds with the alarm raised
	a_buzz_smoke: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.buzzer_drive |-> out_data.smoke)
		else $error("buzzer without smoke");

	// once running, later results stay running
	a_run_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.stage == STAGE_RUN
		|=> !out_valid || out_data.stage == STAGE_RUN)
		else $error("left run stage");

	// an empty pipeline always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!in_valid) && $past(arst_n) |-> in_ready)
		else $error("not ready while empty");

endmodule

bind gas_sensor_ema_alarm_top gsea_checker u_gsea_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/gas_sensor_ema_alarm_top_tb.sv =====
// ---------------------------------------------------------------------------
// gas_sensor_ema_alarm_top_tb: self-checking bench for the gas sensor alarm
// Drives sensor ticks through warmup, calibration and run, and checks every
// status item against a cycle-free model of stage, EMA, baseline and buzzer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gas_sensor_ema_alarm_top_tb;
	import gsea_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	gas_sensor_ema_alarm_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// -----------------------------------------------------------------------
	// Alarm model: own copy of the register file and of the block's state.
	// Updated once per accepted tick; register copy updated on each APB write.
	// -----------------------------------------------------------------------
	cfg_t                   sensor_cfg;
	logic [1:0]             m_stage;
	logic [STIMER_BITS-1:0] m_stage_timer;
	logic [TIMER_BITS-1:0]  m_sample_timer;
	logic [TIMER_BITS-1:0]  m_beep_timer;
	logic [AVG_BITS-1:0]    m_ema;
	logic [AVG_BITS-1:0]    m_baseline;
	bit                     m_ema_full;
	bit                     m_alarm;
	bit                     m_beep_active;
	bit                     m_beep_sounding;

	out_item_t status_q[$];     // statuses still due from the block

	int errors;
	int ticks_sent;
	int statuses_checked;
	int settings_used;
	int alarm_onsets;
	int beep_sequences;
	int run_level;              // sample level the baseline was calibrated on (min 1)

	bit gaps_on;                // input side may idle between ticks
	bit stalls_on;              // result side may hold off ready
	bit dirty_writes;           // set junk above each register's width
	int ready_hold;

	// One tick of the alarm: timers, sample fold, stage change, then alarm
	// and buzzer. Returns the status the block reports for this tick.
	function automatic out_item_t predict_tick(input in_item_t tick);
		out_item_t           status;
		logic [AVG_BITS-1:0] scaled;
		logic [8:0]          weight;
		logic [63:0]         acc;
		logic [RATIO_BITS-1:0] ratio;
		bit                  ratio_hit;
		bit                  gas_now;
		if (~&m_stage_timer) m_stage_timer++;
		if (~&m_sample_timer) m_sample_timer++;
		if (~&m_beep_timer) m_beep_timer++;

		if (m_sample_timer >= sensor_cfg.sample_period) begin
			m_sample_timer = '0;
			scaled = {tick.adc_sample, 8'h00};
			// weights above 1.0 are clipped to 1.0
			weight = (sensor_cfg.alpha_q8 > 9'd256) ? 9'd256 : sensor_cfg.alpha_q8;
			if (!m_ema_full) begin
				m_ema = scaled;
				m_ema_full = 1'b1;
			end else begin
				acc = 64'(weight) * 64'(scaled) + (64'd256 - 64'(weight)) * 64'(m_ema)
					+ 64'd128;
				m_ema = acc[AVG_BITS+7:8];
			end
			if (m_stage == STAGE_WARMUP) begin
				if (m_stage_timer >= sensor_cfg.warmup_ticks) begin
					m_ema_full = 1'b0;
					m_stage_timer = '0;
					m_stage = STAGE_CALIB;
				end
			end else if (m_stage == STAGE_CALIB) begin
				if (m_stage_timer >= sensor_cfg.calib_ticks) begin
					m_baseline = (m_ema < AVG_ONE) ? AVG_ONE : m_ema;
					m_stage = STAGE_RUN;
				end
			end
		end

		if (m_stage == STAGE_RUN) begin
			// hysteresis: the holding ratio applies once the alarm is up
			ratio = m_alarm ? sensor_cfg.fall_ratio_q8 : sensor_cfg.rise_ratio_q8;
			ratio_hit = m_ema_full && (m_baseline != '0)
				&& ((64'(m_ema) << 8) >= 64'(ratio) * 64'(m_baseline));
			gas_now = ratio_hit || !tick.comparator_level;
			if (gas_now && !m_alarm) alarm_onsets++;
			m_alarm = gas_now;
			if (!m_alarm) begin
				m_beep_active = 1'b0;
				m_beep_sounding = 1'b0;
			end else if (!m_beep_active) begin
				m_beep_active = 1'b1;
				m_beep_sounding = 1'b1;
				m_beep_timer = '0;
				beep_sequences++;
			end else if (m_beep_sounding && m_beep_timer >= sensor_cfg.beep_on_ticks) begin
				m_beep_sounding = 1'b0;
				m_beep_timer = '0;
			end else if (!m_beep_sounding && m_beep_timer >= sensor_cfg.beep_off_ticks) begin
				m_beep_sounding = 1'b1;
				m_beep_timer = '0;
			end
		end else begin
			m_beep_active = 1'b0;
			m_beep_sounding = 1'b0;
		end

		status.stage = m_stage;
		status.smoke = m_alarm;
		status.buzzer_drive = m_beep_sounding;
		status.average_q8 = m_ema_full ? m_ema : '0;
		return status;
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus side. Inputs change on the falling edge only.
	// -----------------------------------------------------------------------

	// Send one tick; valid stays up across back-to-back ticks, so it is only
	// lowered when a gap is drawn.
	task automatic send_tick(input in_item_t tick);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= tick;
		do @(posedge clk); while (in_ready !== 1'b1);
		status_q.push_back(predict_tick(tick));
		ticks_sent++;
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val, input int width);
		logic [31:0] wdata;
		wdata = val;
		if (dirty_writes) wdata = val | ($urandom() << width);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		// block keeps only the low bits of each register
		case (idx)
			REG_WARMUP_TICKS:   sensor_cfg.warmup_ticks   = wdata[STIMER_BITS-1:0];
			REG_CALIB_TICKS:    sensor_cfg.calib_ticks    = wdata[STIMER_BITS-1:0];
			REG_SAMPLE_PERIOD:  sensor_cfg.sample_period  = wdata[TIMER_BITS-1:0];
			REG_ALPHA_Q8:       sensor_cfg.alpha_q8       = wdata[ALPHA_BITS-1:0];
			REG_RISE_RATIO_Q8:  sensor_cfg.rise_ratio_q8  = wdata[RATIO_BITS-1:0];
			REG_FALL_RATIO_Q8:  sensor_cfg.fall_ratio_q8  = wdata[RATIO_BITS-1:0];
			REG_BEEP_ON_TICKS:  sensor_cfg.beep_on_ticks  = wdata[TIMER_BITS-1:0];
			REG_BEEP_OFF_TICKS: sensor_cfg.beep_off_ticks = wdata[TIMER_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_registers(input cfg_t c);
		apb_write(REG_WARMUP_TICKS,   32'(c.warmup_ticks),   STIMER_BITS);
		apb_write(REG_CALIB_TICKS,    32'(c.calib_ticks),    STIMER_BITS);
		apb_write(REG_SAMPLE_PERIOD,  32'(c.sample_period),  TIMER_BITS);
		apb_write(REG_ALPHA_Q8,       32'(c.alpha_q8),       ALPHA_BITS);
		apb_write(REG_RISE_RATIO_Q8,  32'(c.rise_ratio_q8),  RATIO_BITS);
		apb_write(REG_FALL_RATIO_Q8,  32'(c.fall_ratio_q8),  RATIO_BITS);
		apb_write(REG_BEEP_ON_TICKS,  32'(c.beep_on_ticks),  TIMER_BITS);
		apb_write(REG_BEEP_OFF_TICKS, 32'(c.beep_off_ticks), TIMER_BITS);
		settings_used++;
	endtask

	// Stop sending and wait until every status is back; the extra cycles
	// cover the two-stage pipeline.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Run-stage traffic: segments hold a level relative to the calibrated one
	// long enough for the EMA to settle and cross the thresholds; a tenth of
	// the ticks are full-range noise, and some segments pull the comparator low.
	task automatic run_ticks(input int count);
		in_item_t tick;
		int       i;
		int       seg_left;
		int       k;
		int       lvl;
		bit       gas_burst;
		seg_left = 0;
		k = 256;
		gas_burst = 1'b0;
		for (i = 0; i < count; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(4, 40);
				k = $urandom_range(128, 480);
				gas_burst = ($urandom_range(0, 7) == 0);
				gaps_on = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);
			end
			seg_left--;
			if ($urandom_range(0, 9) == 0) begin
				lvl = $urandom_range(0, 4095);
			end else begin
				lvl = (run_level * k + int'($urandom_range(0, 255))) / 256
					+ int'($urandom_range(0, 6)) - 3;
				if (lvl < 0) lvl = 0;
				if (lvl > 4095) lvl = 4095;
			end
			tick.adc_sample = lvl[SAMPLE_BITS-1:0];
			tick.comparator_level = gas_burst ? ($urandom_range(0, 3) == 0)
				: ($urandom_range(0, 19) != 0);
			send_tick(tick);
		end
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Reset register values: a few warmup ticks with field extremes; no fold
	// happens yet at the default sample period.
	task automatic test_reset_defaults();
		in_item_t pattern[12];
		int       i;
		pattern = '{'{12'h000, 1'b1}, '{12'hFFF, 1'b0}, '{12'hAAA, 1'b1},
			'{12'h555, 1'b0}, '{12'h000, 1'b0}, '{12'hFFF, 1'b1},
			'{12'h001, 1'b1}, '{12'h800, 1'b0}, '{12'h7FF, 1'b1},
			'{12'hF0F, 1'b0}, '{12'h0F0, 1'b1}, '{12'hFFE, 1'b1}};
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		for (i = 0; i < 12; i++) send_tick(pattern[i]);
	endtask

	// Short warmup and calibration; the baseline is calibrated either on a
	// random level or on all-zero samples, which hits the 1.0 floor.
	task automatic test_stage_sequence();
		cfg_t     c;
		in_item_t tick;
		int       calib_level;
		c = sensor_cfg;
		c.warmup_ticks = STIMER_BITS'($urandom_range(8, 40));
		c.calib_ticks = STIMER_BITS'($urandom_range(0, 40));
		c.sample_period = TIMER_BITS'($urandom_range(1, 4));
		c.alpha_q8 = ALPHA_BITS'($urandom_range(1, 256));
		c.rise_ratio_q8 = RST_RISE_RATIO_Q8;
		c.fall_ratio_q8 = RST_FALL_RATIO_Q8;
		c.beep_on_ticks = 16'd3;
		c.beep_off_ticks = 16'd2;
		calib_level = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(300, 1500);
		run_level = (calib_level == 0) ? 1 : calib_level;
		drain_pipeline();
		set_registers(c);
		while (m_stage != STAGE_RUN) begin
			if (m_stage == STAGE_WARMUP) begin
				tick.adc_sample = SAMPLE_BITS'($urandom_range(0, 4095));
			end else if (calib_level == 0) begin
				tick.adc_sample = '0;
			end else begin
				tick.adc_sample = SAMPLE_BITS'(calib_level
					+ int'($urandom_range(0, 40)) - 20);
			end
			tick.comparator_level = 1'($urandom_range(0, 1));
			send_tick(tick);
		end
	endtask

	// Sample extremes right after entering run, with and without gas.
	task automatic test_run_extremes();
		in_item_t pattern[10];
		int       i;
		pattern = '{'{12'hFFF, 1'b1}, '{12'hFFF, 1'b1}, '{12'hFFF, 1'b1},
			'{12'hFFF, 1'b0}, '{12'h000, 1'b1}, '{12'h000, 1'b1},
			'{12'h000, 1'b1}, '{12'h000, 1'b0}, '{12'h000, 1'b1},
			'{12'hFFF, 1'b1}};
		for (i = 0; i < 10; i++) send_tick(pattern[i]);
	endtask

	// Reset-like ratios with a fast, short beep cadence.
	task automatic test_hysteresis();
		cfg_t c;
		c = sensor_cfg;
		c.sample_period = 16'd1;
		c.alpha_q8 = 9'd64;
		c.rise_ratio_q8 = RST_RISE_RATIO_Q8;
		c.fall_ratio_q8 = RST_FALL_RATIO_Q8;
		c.beep_on_ticks = 16'd3;
		c.beep_off_ticks = 16'd2;
		drain_pipeline();
		set_registers(c);
		run_ticks(350);
	endtask

	// Period zero folds every tick, alpha 1.0 tracks the sample, zero beep
	// lengths toggle the tone every tick; fall ratio zero latches the alarm.
	task automatic test_fast_fold();
		cfg_t c;
		c = sensor_cfg;
		c.sample_period = '0;
		c.alpha_q8 = 9'd256;
		c.rise_ratio_q8 = 10'd1023;
		c.fall_ratio_q8 = '0;
		c.beep_on_ticks = '0;
		c.beep_off_ticks = '0;
		drain_pipeline();
		set_registers(c);
		run_ticks(150);
	endtask

	// Alpha zero: folds leave the EMA unchanged. Rise ratio zero always
	// raises, the maximum fall ratio usually drops it again.
	task automatic test_held_average();
		cfg_t c;
		c = sensor_cfg;
		c.sample_period = 16'd1;
		c.alpha_q8 = '0;
		c.rise_ratio_q8 = '0;
		c.fall_ratio_q8 = 10'd1023;
		c.beep_on_ticks = 16'hFFFF;
		c.beep_off_ticks = 16'd1;
		drain_pipeline();
		set_registers(c);
		run_ticks(150);
	endtask

	// Stage timers, sample period, alpha and beep-off at full scale, written with
	// junk in the unused upper bits; the longest period means no fold in the phase.
	task automatic test_wide_writes();
		cfg_t c;
		c.warmup_ticks = '1;
		c.calib_ticks = '1;
		c.sample_period = '1;
		c.alpha_q8 = '1;
		c.rise_ratio_q8 = 10'd300;
		c.fall_ratio_q8 = 10'd200;
		c.beep_on_ticks = 16'd1;
		c.beep_off_ticks = '1;
		drain_pipeline();
		dirty_writes = 1'b1;
		set_registers(c);
		dirty_writes = 1'b0;
		run_ticks(100);
	endtask

	// Alpha above 1.0 acts as 1.0; stage timers set to zero have no effect
	// once running.
	task automatic test_heavy_alpha();
		cfg_t c;
		c = sensor_cfg;
		c.warmup_ticks = '0;
		c.calib_ticks = '0;
		c.sample_period = 16'd2;
		c.alpha_q8 = 9'd300;
		c.rise_ratio_q8 = 10'd260;
		c.fall_ratio_q8 = 10'd250;
		c.beep_on_ticks = 16'd5;
		c.beep_off_ticks = 16'd7;
		drain_pipeline();
		set_registers(c);
		run_ticks(300);
	endtask

	// Random settings with short periods and beeps so the alarm moves.
	task automatic test_random_configs();
		cfg_t c;
		int   r;
		for (r = 0; r < 4; r++) begin
			c = sensor_cfg;
			c.sample_period = TIMER_BITS'($urandom_range(0, 4));
			c.alpha_q8 = ALPHA_BITS'($urandom_range(0, 511));
			c.rise_ratio_q8 = RATIO_BITS'($urandom_range(200, 450));
			c.fall_ratio_q8 = RATIO_BITS'($urandom_range(150, c.rise_ratio_q8));
			c.beep_on_ticks = TIMER_BITS'($urandom_range(0, 6));
			c.beep_off_ticks = TIMER_BITS'($urandom_range(0, 6));
			drain_pipeline();
			set_registers(c);
			run_ticks(90);
		end
	endtask

	// -----------------------------------------------------------------------
	// Result side: ready drops for a random number of cycles after each
	// status; every accepted status is compared with the oldest prediction.
	// -----------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				out_ready <= 1'b0;
				ready_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : status_check
		out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (status_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected status, expected none, got stage %0d avg %0d",
					$time, out_data.stage, out_data.average_q8);
			end else begin
				want = status_q.pop_front();
				check_field("stage", 32'(want.stage), 32'(out_data.stage));
				check_field("smoke", 32'(want.smoke), 32'(out_data.smoke));
				check_field("buzzer_drive", 32'(want.buzzer_drive), 32'(out_data.buzzer_drive));
				check_field("average_q8", 32'(want.average_q8), 32'(out_data.average_q8));
				statuses_checked++;
			end
			ready_hold = stalls_on ? $urandom_range(0, 4) : 0;
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		ticks_sent = 0;
		statuses_checked = 0;
		settings_used = 0;
		alarm_onsets = 0;
		beep_sequences = 0;
		run_level = 1;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		dirty_writes = 1'b0;
		ready_hold = 0;

		// model starts where reset leaves the block
		sensor_cfg = '{warmup_ticks: RST_WARMUP_TICKS, calib_ticks: RST_CALIB_TICKS,
			sample_period: RST_SAMPLE_PERIOD, alpha_q8: RST_ALPHA_Q8,
			rise_ratio_q8: RST_RISE_RATIO_Q8, fall_ratio_q8: RST_FALL_RATIO_Q8,
			beep_on_ticks: RST_BEEP_ON_TICKS, beep_off_ticks: RST_BEEP_OFF_TICKS};
		m_stage = STAGE_WARMUP;
		m_stage_timer = '0;
		m_sample_timer = '0;
		m_beep_timer = '0;
		m_ema = '0;
		m_baseline = '0;
		m_ema_full = 1'b0;
		m_alarm = 1'b0;
		m_beep_active = 1'b0;
		m_beep_sounding = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_stage_sequence();
		test_run_extremes();
		test_hysteresis();
		test_fast_fold();
		test_held_average();
		test_wide_writes();
		test_heavy_alpha();
		test_random_configs();

		drain_pipeline();
		repeat (8) @(posedge clk);

		$display("Covered %0d ticks and %0d statuses over %0d register settings.",
			ticks_sent, statuses_checked, settings_used);
		$display("Saw %0d alarm onsets and %0d beep sequences; baseline %0d in Q8.",
			alarm_onsets, beep_sequences, m_baseline);
		if (errors == 0 && status_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gsea_pkg.sv
rtl/gsea_apb_regs.sv
rtl/gsea_ema.sv
rtl/gsea_core.sv
rtl/gas_sensor_ema_alarm_top.sv
rtl/gsea_checker.sv
tb/gas_sensor_ema_alarm_top_tb.sv
